// File: hw/rtl/combined_lcg_shuffle_rng_assert.svh
// Assertion macros used by the generator's top-level RTL file.
`ifndef COMBINED_LCG_SHUFFLE_RNG_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define CLSR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("combined_lcg_shuffle_rng: assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define CLSR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("combined_lcg_shuffle_rng: assertion failed");

`endif

// File: hw/rtl/clsr_pkg.sv
package clsr_pkg;

    // Shuffle table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Warm-up: extra discarded steps before the table fill
    localparam int WARM_EXTRA = 8;
    localparam int WARM_STEPS = TABLE_DEPTH + WARM_EXTRA;
    localparam int WARM_CW    = $clog2(WARM_STEPS);

    // Datapath widths
    localparam int VAL_W    = 31;
    localparam int MUL_W    = 16;
    localparam int FOLD_W   = 8;
    localparam int PROD_W   = VAL_W + MUL_W;
    localparam int SPROD_W  = 2 * VAL_W;
    localparam int R1_W     = VAL_W + FOLD_W;

    // Generator constants
    localparam logic [VAL_W-1:0] MOD1   = 31'd2147483563;
    localparam logic [VAL_W-1:0] MOD2   = 31'd2147483399;
    localparam logic [VAL_W-1:0] MOD1M1 = MOD1 - 31'd1;
    localparam logic [MUL_W-1:0] MUL1   = 16'd40014;
    localparam logic [MUL_W-1:0] MUL2   = 16'd40692;

    // 2^31 mod m for each modulus (m = 2^31 - fold)
    localparam logic [FOLD_W-1:0] FOLD1 = FOLD_W'(32'h8000_0000 - 32'(MOD1));
    localparam logic [FOLD_W-1:0] FOLD2 = FOLD_W'(32'h8000_0000 - 32'(MOD2));

    // Table slot width in output space
    localparam logic [31:0] SLOT_DIV = 32'd1 + 32'(MOD1M1) / 32'(TABLE_DEPTH);

    // Table slot of a generator output: count of slot thresholds reached
    function automatic logic [TABLE_AW-1:0] slot_of(input logic [VAL_W-1:0] value);
        logic [TABLE_AW-1:0] slot;
        slot = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if ({1'b0, value} >= 32'(k) * SLOT_DIV) begin
                slot = TABLE_AW'(k);
            end
        end
        return slot;
    endfunction

    // Access request to the shuffle table memory
    typedef struct packed {
        logic                wr_en;
        logic [TABLE_AW-1:0] wr_addr;
        logic [VAL_W-1:0]    wr_data;
        logic                rd_en;
        logic [TABLE_AW-1:0] rd_addr;
    } tbl_req_t;

endpackage

// File: hw/rtl/combined_lcg_shuffle_rng.sv
// Combined two-generator random source with a 32-entry shuffle table.
// Input channel (s_valid/s_ready/s_bound): one beat requests one draw with bound n.
// Result channel (m_valid/m_ready): m_raw_value is the shuffled value in
// 1..2147483562, m_scaled_value is floor(raw * n / 2147483563), below n (0 for n = 0).
// Config: cfg_wr_en/cfg_wr_data write the seed (0 acts as 1) and force a reseed;
// write only while no draw is in flight.
// Flow: a draw passes the table read-modify-write (read, write, combine), then the
// scaling multiply and fold, before m_valid rises; s_ready returns only when the
// result is loaded into the output register, so draws do not overlap.
// The first draw after reset or a seed write is preceded by the warm-up: 40
// generator steps, each a registered product then a modular fold, the last 32
// filling the table in the shared memory.
// Reset (aresetn low, synchronous) loads seed 1, marks a reseed pending and
// drops m_valid. A stalled receiver holds the result in the output register;
// the block still takes the next beat and finishes it up to the output stage,
// where it waits until the held result is taken.
`include "combined_lcg_shuffle_rng_assert.svh"

module combined_lcg_shuffle_rng (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [clsr_pkg::VAL_W-1:0]  s_bound,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [clsr_pkg::VAL_W-1:0]  m_raw_value,
    output logic [clsr_pkg::VAL_W-1:0]  m_scaled_value,
    input  logic                        cfg_wr_en,
    input  logic [clsr_pkg::VAL_W-1:0]  cfg_wr_data
);

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_WARM_MUL   = 9'b000000010,
        ST_WARM_CAP   = 9'b000000100,
        ST_DRAW_MUL   = 9'b000001000,
        ST_DRAW_CAP   = 9'b000010000,
        ST_DRAW_MIX   = 9'b000100000,
        ST_SCALE_MUL  = 9'b001000000,
        ST_SCALE_FOLD = 9'b010000000,
        ST_SCALE_OUT  = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [clsr_pkg::VAL_W-1:0]      seed_reg, seed_next;
    logic                            reseed_pending_reg, reseed_pending_next;
    logic [clsr_pkg::VAL_W-1:0]      bound_reg, bound_next;
    logic [clsr_pkg::VAL_W-1:0]      lcg1_reg, lcg1_next;
    logic [clsr_pkg::VAL_W-1:0]      lcg2_reg, lcg2_next;
    logic [clsr_pkg::VAL_W-1:0]      last_output_reg, last_output_next;
    logic [clsr_pkg::TABLE_AW-1:0]   slot_reg, slot_next;
    logic [clsr_pkg::WARM_CW-1:0]    warm_cnt_reg, warm_cnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic [clsr_pkg::VAL_W-1:0]      m_raw_value_reg, m_raw_value_next;
    logic [clsr_pkg::VAL_W-1:0]      m_scaled_value_reg, m_scaled_value_next;

    logic [clsr_pkg::VAL_W-1:0]      r1;
    logic [clsr_pkg::VAL_W-1:0]      r2;
    logic [clsr_pkg::VAL_W-1:0]      tbl_rd_data;
    logic [clsr_pkg::VAL_W-1:0]      quotient;
    logic [clsr_pkg::VAL_W-1:0]      seed_eff;
    logic [clsr_pkg::VAL_W:0]        diff;
    logic [clsr_pkg::VAL_W:0]        iy_adj;
    clsr_pkg::tbl_req_t              tbl_req;

    // First generator step unit
    clsr_modmul u_gen1 (
        .aclk       (aclk),
        .z_in       (lcg1_reg),
        .mult_in    (clsr_pkg::MUL1),
        .fold_in    (clsr_pkg::FOLD1),
        .modulus_in (clsr_pkg::MOD1),
        .result     (r1)
    );

    // Second generator step unit
    clsr_modmul u_gen2 (
        .aclk       (aclk),
        .z_in       (lcg2_reg),
        .mult_in    (clsr_pkg::MUL2),
        .fold_in    (clsr_pkg::FOLD2),
        .modulus_in (clsr_pkg::MOD2),
        .result     (r2)
    );

    // Shuffle table memory
    clsr_table u_table (
        .aclk    (aclk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    // Scaling into [0, bound)
    clsr_scale u_scale (
        .aclk     (aclk),
        .iy       (last_output_reg),
        .bound    (bound_reg),
        .quotient (quotient)
    );

    // Seed with zero taken as one
    assign seed_eff = (seed_reg == '0) ? clsr_pkg::VAL_W'(1) : seed_reg;

    // Combine table entry and second generator, wrap into 1..MOD1-1
    always_comb begin
        diff   = {1'b0, tbl_rd_data} - {1'b0, lcg2_reg};
        iy_adj = (diff[clsr_pkg::VAL_W] || diff == '0) ? diff + {1'b0, clsr_pkg::MOD1M1}
                                                       : diff;
    end

    // Sequencer and next-state logic
    always_comb begin
        state_next          = state_reg;
        seed_next           = seed_reg;
        reseed_pending_next = reseed_pending_reg;
        bound_next          = bound_reg;
        lcg1_next           = lcg1_reg;
        lcg2_next           = lcg2_reg;
        last_output_next    = last_output_reg;
        slot_next           = slot_reg;
        warm_cnt_next       = warm_cnt_reg;
        m_valid_next        = m_valid_reg;
        m_raw_value_next    = m_raw_value_reg;
        m_scaled_value_next = m_scaled_value_reg;

        tbl_req         = '0;
        tbl_req.rd_addr = clsr_pkg::slot_of(last_output_reg);
        tbl_req.wr_addr = slot_reg;
        tbl_req.wr_data = r1;

        // Drop the result once the beat is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bound_next = s_bound;
                    if (reseed_pending_reg) begin
                        lcg1_next     = seed_eff;
                        lcg2_next     = seed_eff;
                        warm_cnt_next = clsr_pkg::WARM_CW'(clsr_pkg::WARM_STEPS - 1);
                        state_next    = ST_WARM_MUL;
                    end else begin
                        state_next = ST_DRAW_MUL;
                    end
                end
            end
            ST_WARM_MUL: begin
                state_next = ST_WARM_CAP;
            end
            ST_WARM_CAP: begin
                // Advance generator one; the last TABLE_DEPTH values fill the table
                lcg1_next = r1;
                if (warm_cnt_reg < clsr_pkg::WARM_CW'(clsr_pkg::TABLE_DEPTH)) begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = warm_cnt_reg[clsr_pkg::TABLE_AW-1:0];
                end
                if (warm_cnt_reg == '0) begin
                    last_output_next    = r1;
                    reseed_pending_next = 1'b0;
                    state_next          = ST_DRAW_MUL;
                end else begin
                    warm_cnt_next = warm_cnt_reg - clsr_pkg::WARM_CW'(1);
                    state_next    = ST_WARM_MUL;
                end
            end
            ST_DRAW_MUL: begin
                // Read the slot picked by the previous output
                tbl_req.rd_en = 1'b1;
                slot_next     = tbl_req.rd_addr;
                state_next    = ST_DRAW_CAP;
            end
            ST_DRAW_CAP: begin
                // Advance both generators; write first generator back into the slot
                lcg1_next     = r1;
                lcg2_next     = r2;
                tbl_req.wr_en = 1'b1;
                state_next    = ST_DRAW_MIX;
            end
            ST_DRAW_MIX: begin
                last_output_next = iy_adj[clsr_pkg::VAL_W-1:0];
                state_next       = ST_SCALE_MUL;
            end
            ST_SCALE_MUL: begin
                state_next = ST_SCALE_FOLD;
            end
            ST_SCALE_FOLD: begin
                state_next = ST_SCALE_OUT;
            end
            ST_SCALE_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_raw_value_next    = last_output_reg;
                    m_scaled_value_next = quotient;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Seed write forces a reseed on the next draw
        if (cfg_wr_en) begin
            seed_next           = cfg_wr_data;
            reseed_pending_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            seed_reg           <= clsr_pkg::VAL_W'(1);
            reseed_pending_reg <= 1'b1;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            seed_reg           <= seed_next;
            reseed_pending_reg <= reseed_pending_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        bound_reg          <= bound_next;
        lcg1_reg           <= lcg1_next;
        lcg2_reg           <= lcg2_next;
        last_output_reg    <= last_output_next;
        slot_reg           <= slot_next;
        warm_cnt_reg       <= warm_cnt_next;
        m_raw_value_reg    <= m_raw_value_next;
        m_scaled_value_reg <= m_scaled_value_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_raw_value    = m_raw_value_reg;
    assign m_scaled_value = m_scaled_value_reg;

    // A draw taken with a reseed pending starts the warm-up
    `CLSR_ASSERT_NXT(a_reseed_warm, aclk, aresetn, s_valid && s_ready && reseed_pending_reg, state_reg == ST_WARM_MUL)

    // Table write-back goes to the entry read in the previous cycle
    `CLSR_ASSERT_IMP(a_rmw_same_slot, aclk, aresetn, state_reg == ST_DRAW_CAP, tbl_req.wr_addr == $past(tbl_req.rd_addr))

    // A delivered raw value lies in 1..MOD1-1
    `CLSR_ASSERT_IMP(a_raw_range, aclk, aresetn, m_valid_reg, m_raw_value_reg != '0 && m_raw_value_reg < clsr_pkg::MOD1)

endmodule

// File: hw/rtl/clsr_modmul.sv
// Modular multiply by a small constant, m = 2^31 - fold.
// Product is registered; the fold back into [0, m) follows it.
module clsr_modmul (
    input  logic                          aclk,
    input  logic [clsr_pkg::VAL_W-1:0]    z_in,
    input  logic [clsr_pkg::MUL_W-1:0]    mult_in,
    input  logic [clsr_pkg::FOLD_W-1:0]   fold_in,
    input  logic [clsr_pkg::VAL_W-1:0]    modulus_in,
    output logic [clsr_pkg::VAL_W-1:0]    result
);

    logic [clsr_pkg::PROD_W-1:0]                 product_reg;
    logic [clsr_pkg::MUL_W+clsr_pkg::FOLD_W-1:0] hi_fold;
    logic [clsr_pkg::VAL_W:0]                    sum;

    // Register the full product
    always_ff @(posedge aclk) begin
        product_reg <= clsr_pkg::PROD_W'(z_in) * clsr_pkg::PROD_W'(mult_in);
    end

    // Fold the upper bits back (2^31 == fold mod m), then one conditional subtract
    always_comb begin
        hi_fold = (clsr_pkg::MUL_W + clsr_pkg::FOLD_W)'(
                      product_reg[clsr_pkg::PROD_W-1:clsr_pkg::VAL_W])
                * (clsr_pkg::MUL_W + clsr_pkg::FOLD_W)'(fold_in);
        sum = (clsr_pkg::VAL_W + 1)'(hi_fold)
            + (clsr_pkg::VAL_W + 1)'(product_reg[clsr_pkg::VAL_W-1:0]);
        if (sum >= {1'b0, modulus_in}) begin
            result = clsr_pkg::VAL_W'(sum - {1'b0, modulus_in});
        end else begin
            result = sum[clsr_pkg::VAL_W-1:0];
        end
    end

endmodule

// File: hw/rtl/clsr_scale.sv
// floor(iy * bound / MOD1) as a multiply followed by two folding stages.
// Result follows the product and fold registers and is held while the operands hold.
module clsr_scale (
    input  logic                        aclk,
    input  logic [clsr_pkg::VAL_W-1:0]  iy,
    input  logic [clsr_pkg::VAL_W-1:0]  bound,
    output logic [clsr_pkg::VAL_W-1:0]  quotient
);

    logic [clsr_pkg::SPROD_W-1:0] prod_reg;
    logic [clsr_pkg::VAL_W-1:0]   qhi_reg;
    logic [clsr_pkg::R1_W-1:0]    r1_reg;
    logic [clsr_pkg::FOLD_W-1:0]  h2;
    logic [clsr_pkg::VAL_W:0]     r2;
    logic [clsr_pkg::VAL_W:0]     quot;

    // Stage 1: full product
    always_ff @(posedge aclk) begin
        prod_reg <= clsr_pkg::SPROD_W'(iy) * clsr_pkg::SPROD_W'(bound);
    end

    // Stage 2: P = H*m + (H*fold + L); keep H as the coarse quotient
    always_ff @(posedge aclk) begin
        qhi_reg <= prod_reg[clsr_pkg::SPROD_W-1:clsr_pkg::VAL_W];
        r1_reg  <= clsr_pkg::R1_W'(prod_reg[clsr_pkg::SPROD_W-1:clsr_pkg::VAL_W])
                 * clsr_pkg::R1_W'(clsr_pkg::FOLD1)
                 + clsr_pkg::R1_W'(prod_reg[clsr_pkg::VAL_W-1:0]);
    end

    // Stage 3: fold the small remainder once more, then one final correction
    always_comb begin
        h2   = r1_reg[clsr_pkg::R1_W-1:clsr_pkg::VAL_W];
        r2   = (clsr_pkg::VAL_W + 1)'(h2) * (clsr_pkg::VAL_W + 1)'(clsr_pkg::FOLD1)
             + (clsr_pkg::VAL_W + 1)'(r1_reg[clsr_pkg::VAL_W-1:0]);
        quot = (clsr_pkg::VAL_W + 1)'(qhi_reg) + (clsr_pkg::VAL_W + 1)'(h2)
             + (clsr_pkg::VAL_W + 1)'(r2 >= {1'b0, clsr_pkg::MOD1});
        quotient = quot[clsr_pkg::VAL_W-1:0];
    end

endmodule

// File: hw/rtl/clsr_table.sv
// Shuffle table: one write port, one read port with registered read data.
module clsr_table (
    input  logic                        aclk,
    input  clsr_pkg::tbl_req_t          req,
    output logic [clsr_pkg::VAL_W-1:0]  rd_data
);

    logic [clsr_pkg::VAL_W-1:0] mem [clsr_pkg::TABLE_DEPTH];
    logic [clsr_pkg::VAL_W-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = clsr_pkg::VAL_W;

    // Generator constants for the predictor
    localparam longint MOD_A     = 64'd2147483563;
    localparam longint MUL_A     = 64'd40014;
    localparam longint QUO_A     = 64'd53668;
    localparam longint REM_A     = 64'd12211;
    localparam longint MOD_B     = 64'd2147483399;
    localparam longint MUL_B     = 64'd40692;
    localparam longint QUO_B     = 64'd52774;
    localparam longint REM_B     = 64'd3791;
    localparam int     DEPTH     = 32;
    localparam int     WARM      = DEPTH + 8;
    localparam longint SLOT_SPAN = 64'd1 + (MOD_A - 64'd1) / DEPTH;

    localparam int STREAM_DRAWS = 1800;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [W-1:0] raw;
        logic [W-1:0] scaled;
    } draw_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         s_valid     = 1'b0;
    logic         s_ready;
    logic [W-1:0] s_bound     = '0;
    logic         m_valid;
    logic         m_ready     = 1'b0;
    logic [W-1:0] m_raw_value;
    logic [W-1:0] m_scaled_value;
    logic         cfg_wr_en   = 1'b0;
    logic [W-1:0] cfg_wr_data = '0;

    // Predictor state
    logic [W-1:0] seed_reg   = 31'd1;
    logic         reseed_due = 1'b1;
    longint       gen_a;
    longint       gen_b;
    longint       prev_out;
    longint       shuffle [DEPTH];

    draw_t pending_draws [$];

    int  err_count     = 0;
    int  draws_sent    = 0;
    int  draws_checked = 0;
    int  seed_writes   = 0;
    int  cycle_count   = 0;
    int  stall_left    = 0;
    bit  src_idle      = 1'b0;
    bit  snk_idle      = 1'b0;

    combined_lcg_shuffle_rng uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_bound        (s_bound),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_raw_value    (m_raw_value),
        .m_scaled_value (m_scaled_value),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Count cycles for the watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    // One Schrage-form step: mul * z mod modulus without overflow
    function automatic longint lcg_step(input longint z, input longint mul,
                                        input longint quo, input longint rem,
                                        input longint modulus);
        longint k;
        longint v;
        k = z / quo;
        v = mul * (z - k * quo) - k * rem;
        if (v < 0) begin
            v += modulus;
        end
        return v;
    endfunction

    // Reload both generators from the seed and refill the shuffle table
    function automatic void reload_table();
        longint s;
        s = (seed_reg == '0) ? 64'd1 : longint'(seed_reg);
        gen_a = s;
        gen_b = s;
        for (int i = WARM - 1; i >= 0; i--) begin
            gen_a = lcg_step(gen_a, MUL_A, QUO_A, REM_A, MOD_A);
            if (i < DEPTH) begin
                shuffle[i] = gen_a;
            end
        end
        prev_out   = shuffle[0];
        reseed_due = 1'b0;
    endfunction

    // Advance the predictor by one draw and return the expected beat
    function automatic draw_t next_draw(input logic [W-1:0] bound);
        longint slot;
        longint iy;
        draw_t  d;
        if (reseed_due) begin
            reload_table();
        end
        gen_a = lcg_step(gen_a, MUL_A, QUO_A, REM_A, MOD_A);
        gen_b = lcg_step(gen_b, MUL_B, QUO_B, REM_B, MOD_B);
        slot = prev_out / SLOT_SPAN;
        if (slot > DEPTH - 1) begin
            slot = DEPTH - 1;
        end
        iy = shuffle[slot] - gen_b;
        shuffle[slot] = gen_a;
        if (iy < 1) begin
            iy += MOD_A - 1;
        end
        prev_out = iy;
        d.raw    = W'(iy);
        d.scaled = W'((iy * longint'(bound)) / MOD_A);
        return d;
    endfunction

    // Check each result beat against the oldest expected draw
    always @(posedge aclk) begin
        draw_t exp_d;
        if (aresetn && m_valid && m_ready) begin
            stall_left = snk_idle ? int'($urandom_range(0, 4)) : 0;
            if (pending_draws.size() == 0) begin
                $error("result beat with no draw outstanding: raw %0d scaled %0d",
                       m_raw_value, m_scaled_value);
                err_count++;
            end else begin
                exp_d = pending_draws.pop_front();
                draws_checked++;
                if (m_raw_value !== exp_d.raw) begin
                    $error("raw_value mismatch: expected %0d, actual %0d",
                           exp_d.raw, m_raw_value);
                    err_count++;
                end
                if (m_scaled_value !== exp_d.scaled) begin
                    $error("scaled_value mismatch: expected %0d, actual %0d",
                           exp_d.scaled, m_scaled_value);
                    err_count++;
                end
            end
        end
    end

    // Receiver: hold ready low for the drawn stall after each beat
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Send one draw request and record its expected result
    task automatic send_draw(input logic [W-1:0] bound);
        int gap;
        gap = src_idle ? int'($urandom_range(0, 4)) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_bound <= bound;
        do @(posedge aclk); while (!s_ready);
        pending_draws.push_back(next_draw(bound));
        draws_sent++;
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write the seed register while the block is idle
    task automatic write_seed(input logic [W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en  <= 1'b0;
        seed_reg   = value;
        reseed_due = 1'b1;
        seed_writes++;
    endtask

    function automatic logic [W-1:0] pick_bound();
        case ($urandom_range(0, 3))
            0:       return W'($urandom);
            1:       return W'($urandom_range(0, 16));
            2:       return 31'h7FFF_FFFF - W'($urandom_range(0, 255));
            default: return W'(1) << $urandom_range(0, W - 1);
        endcase
    endfunction

    // Draws under the reset seed, no register write
    task automatic test_reset_seed();
        send_draw(31'h7FFF_FFFF);
        send_draw(31'd1);
        send_draw(31'd0);
        send_draw(31'd2);
    endtask

    // Seed zero, all ones, and each modulus (that generator sticks at zero)
    task automatic test_seed_extremes();
        logic [W-1:0] seeds [4];
        seeds[0] = 31'd0;
        seeds[1] = 31'h7FFF_FFFF;
        seeds[2] = W'(MOD_A);
        seeds[3] = W'(MOD_B);
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            repeat (3) send_draw(pick_bound());
        end
    endtask

    // Bound at zero, one, full scale, alternating bits and near the modulus
    task automatic test_bound_extremes();
        logic [W-1:0] bounds [8];
        bounds[0] = 31'd0;
        bounds[1] = 31'd1;
        bounds[2] = 31'd2;
        bounds[3] = 31'h7FFF_FFFF;
        bounds[4] = 31'h5555_5555;
        bounds[5] = 31'h2AAA_AAAA;
        bounds[6] = W'(MOD_A);
        bounds[7] = W'(MOD_A - 1);
        write_seed(W'($urandom));
        foreach (bounds[i]) begin
            send_draw(bounds[i]);
        end
    endtask

    // Long random stream in phases with fresh seeds and varied idling
    task automatic test_random_stream();
        int target;
        int run_len;
        target = draws_sent + STREAM_DRAWS;
        while (draws_sent < target) begin
            if ($urandom_range(0, 3) != 0) begin
                write_seed(($urandom_range(0, 7) == 0) ? W'($urandom_range(0, 1000))
                                                        : W'($urandom));
            end
            case ($urandom_range(0, 3))
                0:       begin src_idle = 1'b1; snk_idle = 1'b1; end
                1:       begin src_idle = 1'b1; snk_idle = 1'b0; end
                2:       begin src_idle = 1'b0; snk_idle = 1'b1; end
                default: begin src_idle = 1'b0; snk_idle = 1'b0; end
            endcase
            run_len = $urandom_range(60, 240);
            for (int i = 0; i < run_len && draws_sent < target; i++) begin
                send_draw(pick_bound());
                if ($urandom_range(0, 63) == 0) begin
                    drain_results();
                end
            end
        end
    endtask

    initial begin
        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle = 1'b1;
        snk_idle = 1'b1;
        test_reset_seed();
        test_seed_extremes();
        test_bound_extremes();
        test_random_stream();

        // Let the last results come back and the bench settle before the summary
        drain_results();
        repeat (10) @(posedge aclk);

        $display("Covered %0d draws and %0d checked results across %0d seed writes,",
                 draws_sent, draws_checked, seed_writes);
        $display("including zero, all-ones and modulus seeds and full-range bounds.");
        if (err_count == 0 && pending_draws.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/clsr_pkg.sv
hw/rtl/clsr_modmul.sv
hw/rtl/clsr_scale.sv
hw/rtl/clsr_table.sv
hw/rtl/combined_lcg_shuffle_rng.sv
tb/tb_top.sv
